[design/rets_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rets_pkg: shared types and constants of the triad statistic block
// Sizes of the count matrix, item and status structs, codes and helpers.
// ----------------------------------------------------------------------------
package rets_pkg;

	localparam int NUM_ACTORS = 64;
	localparam int COUNT_BITS = 16;
	localparam int ID_BITS    = 6;
	localparam int STAT_BITS  = 22;
	localparam int ACTOR_BITS = $clog2(NUM_ACTORS);
	localparam int ADDR_BITS  = 2 * ACTOR_BITS;
	localparam int MEM_DEPTH  = 1 << ADDR_BITS;
	localparam int ADD_BITS   = ((COUNT_BITS > STAT_BITS) ? COUNT_BITS : STAT_BITS) + 1;

	typedef logic [ACTOR_BITS-1:0] actor_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [ADDR_BITS-1:0]  addr_t;
	typedef logic [STAT_BITS-1:0]  stat_t;
	typedef logic [ID_BITS-1:0]    id_t;

	typedef enum logic [1:0] {
		TRIAD_OUT_TWO_PATH = 2'd0,
		TRIAD_IN_TWO_PATH  = 2'd1,
		TRIAD_OUT_SHARED   = 2'd2,
		TRIAD_IN_SHARED    = 2'd3
	} triad_t;

	typedef enum logic {
		OP_EVENT = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EV_RD,
		ST_EV_WR,
		ST_Q_RUN,
		ST_Q_WAIT
	} eng_state_t;

	// Classified item as it waits between front and engine
	typedef struct packed {
		logic   is_query;
		actor_t first;
		actor_t second;
		logic   first_ok;
		logic   second_ok;
	} item_t;

	// Engine feedback to the front
	typedef struct packed {
		logic pop;
		logic clear_busy;
	} eng_status_t;

	// Matrix cell address of count[row][col]
	function automatic addr_t cell_addr(actor_t row, actor_t col);
		return {row, col};
	endfunction

endpackage

[design/rets_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rets_ram: generic RAM, one write port, two registered read ports
// ----------------------------------------------------------------------------
module rets_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr_a,
	output logic      [WIDTH-1:0] rdata_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read both ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule
`default_nettype wire

[design/rets_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rets_front: input beat acceptance, classification and item queue
// Drops events with an actor out of range and queues the rest, two deep.
// ----------------------------------------------------------------------------
module rets_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [15:0]           s_tdata,
	input  wire logic                  s_tuser,
	input  wire rets_pkg::eng_status_t status,
	output logic                       item_valid,
	output rets_pkg::item_t            item
);
	import rets_pkg::*;

	item_t      entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	id_t        a_id;
	id_t        b_id;
	item_t      new_item;
	logic       push;

	// Classify the incoming beat
	always_comb begin
		a_id               = s_tdata[ID_BITS-1:0];
		b_id               = s_tdata[2*ID_BITS-1:ID_BITS];
		new_item.is_query  = (op_t'(s_tuser) == OP_QUERY);
		new_item.first     = actor_t'(a_id);
		new_item.second    = actor_t'(b_id);
		new_item.first_ok  = (int'(a_id) < NUM_ACTORS);
		new_item.second_ok = (int'(b_id) < NUM_ACTORS);
	end

	assign s_tready   = (cnt_q != 2'd2) && !status.clear_busy;
	assign push       = s_tvalid && s_tready
	                  && (new_item.is_query || (new_item.first_ok && new_item.second_ok));
	assign item_valid = (cnt_q != 2'd0);
	assign item       = entries_q[rd_ptr_q];

	// Store payload
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= new_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (status.pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !status.pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && status.pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

[design/rets_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rets_engine: count matrix, event update and query walk
// Clears the matrix after reset, increments counts, sums pair minima.
// ----------------------------------------------------------------------------
module rets_engine (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire rets_pkg::triad_t      stat_type,
	input  wire logic                  item_valid,
	input  wire rets_pkg::item_t       item,
	output rets_pkg::eng_status_t      status,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [23:0]                m_tdata
);
	import rets_pkg::*;

	localparam logic [ADD_BITS-1:0] STAT_MAX = ADD_BITS'((64'd1 << STAT_BITS) - 64'd1);
	localparam actor_t LAST_ACTOR = actor_t'(NUM_ACTORS - 1);

	eng_state_t state_q;
	eng_state_t state_d;
	item_t      item_q;
	addr_t      clr_addr_q;
	actor_t     h_q;
	logic       v_s1;
	logic       use_s1;
	logic       v_s2;
	count_t     min_s2;
	stat_t      sum_q;
	logic       out_valid_q;
	stat_t      out_data_q;

	logic       we;
	addr_t      waddr;
	count_t     wdata;
	addr_t      raddr_p;
	addr_t      raddr_q;
	count_t     rdata_p;
	count_t     rdata_q;
	logic       issue;
	logic       skip;
	logic       out_free;
	logic       load_out;
	logic       start;
	count_t     cp;
	count_t     cq;
	logic [ADD_BITS-1:0] sum_ext;

	rets_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(MEM_DEPTH)
	) u_counts (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_p),
		.rdata_a (rdata_p),
		.raddr_b (raddr_q),
		.rdata_b (rdata_q)
	);

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(24 - STAT_BITS){1'b0}}, out_data_q};

	// Select read addresses for the triad type
	always_comb begin
		raddr_p = cell_addr(item_q.first, h_q);
		raddr_q = cell_addr(h_q, item_q.second);
		unique case (stat_type)
			TRIAD_OUT_TWO_PATH: begin
				raddr_p = cell_addr(item_q.first, h_q);
				raddr_q = cell_addr(h_q, item_q.second);
			end
			TRIAD_IN_TWO_PATH: begin
				raddr_p = cell_addr(h_q, item_q.first);
				raddr_q = cell_addr(item_q.second, h_q);
			end
			TRIAD_OUT_SHARED: begin
				raddr_p = cell_addr(item_q.first, h_q);
				raddr_q = cell_addr(item_q.second, h_q);
			end
			TRIAD_IN_SHARED: begin
				raddr_p = cell_addr(h_q, item_q.first);
				raddr_q = cell_addr(h_q, item_q.second);
			end
			default: begin
				raddr_p = cell_addr(item_q.first, h_q);
				raddr_q = cell_addr(h_q, item_q.second);
			end
		endcase
		if (state_q == ST_EV_RD) begin
			raddr_p = cell_addr(item_q.first, item_q.second);
		end
	end

	// Skip the dyad's own actors as third actors
	assign skip = (item_q.first_ok && (h_q == item_q.first))
	           || (item_q.second_ok && (h_q == item_q.second));

	// Next state and control
	always_comb begin
		state_d           = state_q;
		we                = 1'b0;
		waddr             = cell_addr(item_q.first, item_q.second);
		wdata             = rdata_p + count_t'(1);
		issue             = 1'b0;
		load_out          = 1'b0;
		start             = 1'b0;
		status.pop        = 1'b0;
		status.clear_busy = (state_q == ST_CLEAR);
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_addr_q;
				wdata = '0;
				if (&clr_addr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					status.pop = 1'b1;
					start      = 1'b1;
					state_d    = item.is_query ? ST_Q_RUN : ST_EV_RD;
				end
			end
			ST_EV_RD: begin
				state_d = ST_EV_WR;
			end
			ST_EV_WR: begin
				we      = !(&rdata_p);
				state_d = ST_IDLE;
			end
			ST_Q_RUN: begin
				issue = 1'b1;
				if (h_q == LAST_ACTOR) begin
					state_d = ST_Q_WAIT;
				end
			end
			ST_Q_WAIT: begin
				if (!v_s1 && !v_s2 && out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Mask out-of-range actors and widen the running sum for the add
	always_comb begin
		cp      = item_q.first_ok ? rdata_p : '0;
		cq      = item_q.second_ok ? rdata_q : '0;
		sum_ext = ADD_BITS'(sum_q) + ADD_BITS'(min_s2);
	end

	// State, sweep counter and walk pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + addr_t'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1 && use_s1;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: item, third actor, minimum, running sum, result
	always_ff @(posedge clk) begin
		if (start) begin
			item_q <= item;
			h_q    <= '0;
			sum_q  <= '0;
		end else begin
			if (issue) begin
				h_q <= h_q + actor_t'(1);
			end
			if (v_s2) begin
				sum_q <= (sum_ext > STAT_MAX) ? STAT_BITS'(STAT_MAX) : STAT_BITS'(sum_ext);
			end
		end
		use_s1 <= !skip;
		min_s2 <= (cp < cq) ? cp : cq;
		if (load_out) begin
			out_data_q <= sum_q;
		end
	end

endmodule
`default_nettype wire

[design/relational_event_triad_statistic.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// relational_event_triad_statistic: directed event counts and triad queries
// Keeps a saturating count matrix over actors and sums triad pair minima.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_*: s_tuser picks event (0) or query (1); s_tdata carries
//   the two actor ids. An event bumps count[first][second] and gives no
//   output. A query gives one beat on m_* with the statistic, computed for
//   the triad type held in the register written through cfg_wen/cfg_wdata.
//   Write that register only while no beat is in flight.
//   An event occupies the engine through its take, read and write steps.
//   A query walks the engine over one third actor per cycle, reading two
//   counts a cycle from the two read ports of the count memory, then drains
//   a two-stage min/add pipeline.
//   A two-deep queue sits in front of the engine and the result has its own
//   output register, so input beats keep flowing while a result waits.
//   Reset: after arst_n releases, a clearing pass zeroes the count memory,
//   one entry per cycle, NUM_ACTORS*NUM_ACTORS entries (4096); s_tready stays
//   low meanwhile, cfg writes are taken. When m_tready is low the result
//   holds, the engine stops at the end of the next query and the queue fills.
// ----------------------------------------------------------------------------
module relational_event_triad_statistic (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [5:0] first_actor, [11:6] second_actor, zero fill
	input  wire logic        s_tuser,   // [0] opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // [21:0] statistic, zero fill
	input  wire logic        cfg_wen,
	input  wire logic [1:0]  cfg_wdata  // stat_type
);
	import rets_pkg::*;

	triad_t      stat_type_q;
	eng_status_t status;
	logic        item_valid;
	item_t       item;

	// Hold the triad type register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_type_q <= TRIAD_OUT_TWO_PATH;
		end else if (cfg_wen) begin
			stat_type_q <= triad_t'(cfg_wdata);
		end
	end

	rets_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.status     (status),
		.item_valid (item_valid),
		.item       (item)
	);

	rets_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.stat_type  (stat_type_q),
		.item_valid (item_valid),
		.item       (item),
		.status     (status),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
`default_nettype wire
